### hw/rtl/ndrp_pkg.sv
// ----------------------------------------------------------------------------
// ndrp_pkg: node descriptor response parser package
// Shared types and constants for the parser's capture and check stages.
// ----------------------------------------------------------------------------
package ndrp_pkg;

   localparam int CAPTURE_DEPTH = 17;
   localparam int COUNT_WIDTH   = 8;
   localparam int IDX_WIDTH     = $clog2(CAPTURE_DEPTH);

   // Result codes.
   localparam logic [2:0] RESULT_OK          = 3'd0;
   localparam logic [2:0] RESULT_TOO_LONG    = 3'd1;
   localparam logic [2:0] RESULT_TRUNCATED   = 3'd2;
   localparam logic [2:0] RESULT_UNSUPPORTED = 3'd3;
   localparam logic [2:0] RESULT_INVALID     = 3'd4;

   // Status codes with a known body length.
   localparam logic [7:0] STATUS_SUCCESS   = 8'h00;
   localparam logic [7:0] STATUS_INV_TYPE  = 8'h80;
   localparam logic [7:0] STATUS_DEV_NF    = 8'h81;
   localparam logic [7:0] STATUS_NO_DESC   = 8'h84;
   localparam logic [7:0] STATUS_NOT_FOUND = 8'h89;

   // Body lengths required per status; zero marks an unknown status.
   localparam logic [COUNT_WIDTH-1:0] LEN_NONE    = 8'd0;
   localparam logic [COUNT_WIDTH-1:0] LEN_MIN     = 8'd2;
   localparam logic [COUNT_WIDTH-1:0] LEN_ADDRESS = 8'd4;
   localparam logic [COUNT_WIDTH-1:0] LEN_FULL    = 8'd17;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = 8'd255;

   // Descriptor range masks and limits.
   localparam logic [7:0] BAND_MASK         = 8'he2;
   localparam logic [7:0] MAC_RSVD_MASK     = 8'h30;
   localparam logic [7:0] BUFFER_SIZE_LIMIT = 8'h7f;
   localparam logic [2:0] LOGICAL_TYPE_MAX  = 3'd2;
   localparam logic [7:0] DESC_CAP_MAX      = 8'd3;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic [7:0]  sequence_res;
      logic [7:0]  status;
      logic [15:0] address;
      logic [4:0]  node_type;
      logic [4:0]  band_flags;
      logic [7:0]  mac_flags;
      logic [15:0] manufacturer;
      logic [6:0]  buffer_size;
      logic [29:0] transfer_sizes;
      logic [13:0] server_word;
      logic [1:0]  desc_flags;
   } rsp_type;

   // One finished body handed from the capture stage to the check stage.
   typedef struct packed {
      logic [CAPTURE_DEPTH-1:0][7:0] bytes;
      logic [COUNT_WIDTH-1:0]        size;
   } snap_type;

endpackage

### hw/rtl/ndrp_capture.sv
// ----------------------------------------------------------------------------
// ndrp_capture: byte counter, capture registers and body snapshot
// Counts body bytes, keeps the first ones and, on the last byte, copies the
// captured bytes and the count into a snapshot register for the check stage.
// ----------------------------------------------------------------------------
module ndrp_capture (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ndrp_pkg::req_type req_data,
   output logic              snap_valid,
   output ndrp_pkg::snap_type snap,
   input  logic              snap_take
);

   logic [ndrp_pkg::COUNT_WIDTH-1:0] count_ff, count_in, count_next;
   logic [ndrp_pkg::CAPTURE_DEPTH-1:0][7:0] cap_ff, cap_in;
   logic               snap_valid_ff, snap_valid_in;
   ndrp_pkg::snap_type snap_ff, snap_in;
   logic               accept;

   assign req_ready = !snap_valid_ff || snap_take;
   assign accept    = req_valid && req_ready;

   // The counter stops at its maximum.
   assign count_next = (count_ff == ndrp_pkg::COUNT_MAX) ? count_ff
                                                         : count_ff + 8'd1;

   always_comb begin
      cap_in = cap_ff;
      for (int i = 0; i < ndrp_pkg::CAPTURE_DEPTH; i++) begin
         if (count_ff == ndrp_pkg::COUNT_WIDTH'(i)) begin
            cap_in[i] = req_data.body_byte;
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      snap_valid_in = snap_valid_ff;
      snap_in       = snap_ff;
      if (snap_take) begin
         snap_valid_in = 1'b0;
      end
      if (accept) begin
         count_in = count_next;
         if (req_data.last_byte) begin
            count_in      = '0;
            snap_valid_in = 1'b1;
            snap_in.bytes = cap_in;
            snap_in.size  = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cap_ff <= cap_in;
      end
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

### hw/rtl/ndrp_check.sv
// ----------------------------------------------------------------------------
// ndrp_check: length and descriptor checks with result register
// Evaluates one captured body and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ndrp_check #(
   parameter int MAX_BODY_BYTES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               snap_valid,
   input  ndrp_pkg::snap_type snap,
   output logic               snap_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ndrp_pkg::rsp_type  rsp_data
);

   logic [ndrp_pkg::CAPTURE_DEPTH-1:0][7:0] b;
   logic [ndrp_pkg::COUNT_WIDTH-1:0] need;
   logic [ndrp_pkg::COUNT_WIDTH-1:0] size;
   logic [2:0]        code;
   logic              bad_desc;
   logic              rsp_valid_ff, rsp_valid_in;
   ndrp_pkg::rsp_type rsp_ff, rsp_in, fields;

   assign b    = snap.bytes;
   assign size = snap.size;

   always_comb begin
      unique case (b[1]) inside
         ndrp_pkg::STATUS_SUCCESS: need = ndrp_pkg::LEN_FULL;
         ndrp_pkg::STATUS_INV_TYPE, ndrp_pkg::STATUS_DEV_NF,
         ndrp_pkg::STATUS_NOT_FOUND: need = ndrp_pkg::LEN_ADDRESS;
         ndrp_pkg::STATUS_NO_DESC: need = ndrp_pkg::LEN_MIN;
         default: need = ndrp_pkg::LEN_NONE;
      endcase
   end

   // Reserved bits and out-of-range descriptor fields.
   assign bad_desc = (b[4][7:5] != 3'd0) || (b[5][2:0] != 3'd0) || b[12][7] || b[13][0]
                  || (b[4][2:0] > ndrp_pkg::LOGICAL_TYPE_MAX)
                  || (({3'd0, b[5][7:3]} & ndrp_pkg::BAND_MASK) != 8'd0)
                  || ((b[6] & ndrp_pkg::MAC_RSVD_MASK) != 8'd0)
                  || (b[9] > ndrp_pkg::BUFFER_SIZE_LIMIT)
                  || b[11][7] || b[15][7]
                  || (b[16] > ndrp_pkg::DESC_CAP_MAX);

   always_comb begin
      if (size > ndrp_pkg::COUNT_WIDTH'(MAX_BODY_BYTES)) begin
         code = ndrp_pkg::RESULT_TOO_LONG;
      end else if (size < ndrp_pkg::LEN_MIN) begin
         code = ndrp_pkg::RESULT_TRUNCATED;
      end else if (need == ndrp_pkg::LEN_NONE) begin
         code = ndrp_pkg::RESULT_UNSUPPORTED;
      end else if (size < need) begin
         code = ndrp_pkg::RESULT_TRUNCATED;
      end else if ((b[1] == ndrp_pkg::STATUS_SUCCESS) && bad_desc) begin
         code = ndrp_pkg::RESULT_INVALID;
      end else begin
         code = ndrp_pkg::RESULT_OK;
      end
   end

   always_comb begin
      fields = '0;
      fields.result_code = code;
      if (code == ndrp_pkg::RESULT_OK) begin
         fields.sequence_res = b[0];
         fields.status       = b[1];
         if (need >= ndrp_pkg::LEN_ADDRESS) begin
            fields.address = {b[3], b[2]};
         end
         if (b[1] == ndrp_pkg::STATUS_SUCCESS) begin
            fields.node_type      = b[4][4:0];
            fields.band_flags     = b[5][7:3];
            fields.mac_flags      = b[6];
            fields.manufacturer   = {b[8], b[7]};
            fields.buffer_size    = b[9][6:0];
            fields.transfer_sizes = {b[15][6:0], b[14], b[11][6:0], b[10]};
            fields.server_word    = {b[13][7:1], b[12][6:0]};
            fields.desc_flags     = b[16][1:0];
         end
      end
   end

   assign snap_take = snap_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (snap_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fields;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/node_descriptor_response_parser.sv
// ----------------------------------------------------------------------------
// node_descriptor_response_parser: node descriptor response body parser
// Takes a response body one byte per request and returns one result per body.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  ndrp_pkg::req_type (byte, last mark)
//   rsp_     out        rsp_valid / rsp_ready  ndrp_pkg::rsp_type (code, fields)
//
// One request is accepted per cycle while req_ready is high. A finished body
// passes through the snapshot register and then the result register before
// rsp_valid rises for it. Reset is synchronous and active high; it clears the
// byte counter and both valid flags. When a low rsp_ready holds the result
// register and a second finished body waits in the snapshot register,
// req_ready is low until rsp_ready returns; the input stage stalls only in
// that case.
//
module node_descriptor_response_parser #(
   parameter int MAX_BODY_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ndrp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ndrp_pkg::rsp_type rsp_data
);

   // Finished body passed from the capture stage to the check stage.
   ndrp_pkg::snap_type snap;
   logic               snap_valid;
   logic               snap_take;

   // Counts the bytes of the body and keeps the first seventeen; the last
   // byte of a body is merged into a snapshot register.
   ndrp_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_take  (snap_take)
   );

   // Runs the length, status and descriptor checks on the snapshot and
   // registers the result for the response channel.
   ndrp_check #(
      .MAX_BODY_BYTES (MAX_BODY_BYTES)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_take  (snap_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### test/node_descriptor_response_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_descriptor_response_checker: result predictor and scoreboard
// Watches both channels of the parser, predicts each body's result from the
// accepted bytes and compares every returned result field by field.
// ----------------------------------------------------------------------------
module node_descriptor_response_checker #(
   parameter int MAX_BODY_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ndrp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ndrp_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                pending_results
);

   localparam int REPORT_LIMIT = 10;

   logic [ndrp_pkg::COUNT_WIDTH-1:0] body_length = '0;
   logic [7:0]             body_capture [ndrp_pkg::CAPTURE_DEPTH];
   ndrp_pkg::rsp_type      expected_results [$];
   ndrp_pkg::rsp_type      want;
   int                     mismatches   = 0;
   int                     pending      = 0;
   int                     results_seen = 0;

   assign mismatch_count  = mismatches;
   assign pending_results = pending;

   // Computes the result of the body held in body_capture, of the given length.
   function automatic ndrp_pkg::rsp_type parse_body(
      input logic [ndrp_pkg::COUNT_WIDTH-1:0] size);
      ndrp_pkg::rsp_type                r;
      logic [ndrp_pkg::COUNT_WIDTH-1:0] need;
      logic [2:0]                       code;
      logic [15:0]                      incoming;
      logic [15:0]                      outgoing;
      logic                             bad;

      r    = '0;
      code = ndrp_pkg::RESULT_OK;
      case (body_capture[1])
         ndrp_pkg::STATUS_SUCCESS: need = ndrp_pkg::LEN_FULL;
         ndrp_pkg::STATUS_INV_TYPE, ndrp_pkg::STATUS_DEV_NF,
         ndrp_pkg::STATUS_NOT_FOUND: need = ndrp_pkg::LEN_ADDRESS;
         ndrp_pkg::STATUS_NO_DESC: need = ndrp_pkg::LEN_MIN;
         default: need = ndrp_pkg::LEN_NONE;
      endcase

      // The length checks come first, so no unwritten entry is ever used.
      if (int'(size) > MAX_BODY_BYTES) begin
         code = ndrp_pkg::RESULT_TOO_LONG;
      end else if (size < ndrp_pkg::LEN_MIN) begin
         code = ndrp_pkg::RESULT_TRUNCATED;
      end else if (need == ndrp_pkg::LEN_NONE) begin
         code = ndrp_pkg::RESULT_UNSUPPORTED;
      end else if (size < need) begin
         code = ndrp_pkg::RESULT_TRUNCATED;
      end else begin
         r.sequence_res = body_capture[0];
         r.status       = body_capture[1];
         if (need >= ndrp_pkg::LEN_ADDRESS) begin
            r.address = {body_capture[3], body_capture[2]};
         end
         if (body_capture[1] == ndrp_pkg::STATUS_SUCCESS) begin
            incoming = {body_capture[11], body_capture[10]};
            outgoing = {body_capture[15], body_capture[14]};
            // A transfer size above 0x7fff is exactly one with bit 15 set.
            bad = (body_capture[4][7:5] != '0) || (body_capture[5][2:0] != '0)
               || body_capture[12][7] || body_capture[13][0]
               || (body_capture[4][2:0] > ndrp_pkg::LOGICAL_TYPE_MAX)
               || (({3'b000, body_capture[5][7:3]} & ndrp_pkg::BAND_MASK) != '0)
               || ((body_capture[6] & ndrp_pkg::MAC_RSVD_MASK) != '0)
               || (body_capture[9] > ndrp_pkg::BUFFER_SIZE_LIMIT)
               || incoming[15] || outgoing[15]
               || (body_capture[16] > ndrp_pkg::DESC_CAP_MAX);
            if (bad) begin
               code = ndrp_pkg::RESULT_INVALID;
            end else begin
               r.node_type      = body_capture[4][4:0];
               r.band_flags     = body_capture[5][7:3];
               r.mac_flags      = body_capture[6];
               r.manufacturer   = {body_capture[8], body_capture[7]};
               r.buffer_size    = body_capture[9][6:0];
               r.transfer_sizes = {outgoing[14:0], incoming[14:0]};
               r.server_word    = {body_capture[13][7:1], body_capture[12][6:0]};
               r.desc_flags     = body_capture[16][1:0];
            end
         end
      end

      if (code != ndrp_pkg::RESULT_OK) begin
         r = '0;
      end
      r.result_code = code;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] expected,
                                input logic [31:0] actual);
      if (expected !== actual) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch in result %0d, %s: expected 0x%0h, actual 0x%0h",
                     results_seen, name, expected, actual);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         body_length = '0;
         foreach (body_capture[i]) body_capture[i] = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected result %0d: 0x%0h", results_seen, rsp_data);
               end
            end else begin
               want = expected_results.pop_front();
               compare_field("result_code", 32'(want.result_code),
                             32'(rsp_data.result_code));
               compare_field("sequence_res", 32'(want.sequence_res),
                             32'(rsp_data.sequence_res));
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
               compare_field("address", 32'(want.address), 32'(rsp_data.address));
               compare_field("node_type", 32'(want.node_type),
                             32'(rsp_data.node_type));
               compare_field("band_flags", 32'(want.band_flags),
                             32'(rsp_data.band_flags));
               compare_field("mac_flags", 32'(want.mac_flags),
                             32'(rsp_data.mac_flags));
               compare_field("manufacturer", 32'(want.manufacturer),
                             32'(rsp_data.manufacturer));
               compare_field("buffer_size", 32'(want.buffer_size),
                             32'(rsp_data.buffer_size));
               compare_field("transfer_sizes", 32'(want.transfer_sizes),
                             32'(rsp_data.transfer_sizes));
               compare_field("server_word", 32'(want.server_word),
                             32'(rsp_data.server_word));
               compare_field("desc_flags", 32'(want.desc_flags),
                             32'(rsp_data.desc_flags));
            end
            results_seen++;
         end

         if (req_valid && req_ready) begin
            if (body_length < ndrp_pkg::COUNT_WIDTH'(ndrp_pkg::CAPTURE_DEPTH)) begin
               body_capture[body_length[ndrp_pkg::IDX_WIDTH-1:0]] = req_data.body_byte;
            end
            if (body_length != ndrp_pkg::COUNT_MAX) begin
               body_length = body_length + ndrp_pkg::COUNT_WIDTH'(1);
            end
            if (req_data.last_byte) begin
               expected_results.push_back(parse_body(body_length));
               body_length = '0;
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

### test/node_descriptor_response_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_descriptor_response_parser_tb: parser testbench top
// Feeds response bodies byte by byte, directed ones first and then random
// well-formed, broken and oversized ones, under changing back pressure. The
// checker beside the parser predicts and compares every result.
// ----------------------------------------------------------------------------
module node_descriptor_response_parser_tb;

   localparam int MAX_BODY_BYTES  = 64;
   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 550;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ndrp_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ndrp_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pending_results;

   // Idle rates of the two sides, in percent, changed from phase to phase.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Cycles left in a long receiver hold-off; counted down by the receiver.
   int hold_off_left = 0;

   int          cycle_count = 0;
   int          items_sent  = 0;
   logic [7:0]  body_q [$];

   node_descriptor_response_parser #(
      .MAX_BODY_BYTES(MAX_BODY_BYTES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   node_descriptor_response_checker #(
      .MAX_BODY_BYTES(MAX_BODY_BYTES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_results(pending_results)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Guards against a hung handshake. Any correct run ends far below the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL node_descriptor_response_parser");
         $finish;
      end
   end

   // The receiver. Outside a hold-off it drops ready at the current idle rate.
   // During a hold-off it keeps ready low for the whole stretch, so the parser
   // has to fill its result and snapshot stages and then stall the sender.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offers one request and returns at the edge where it is accepted. The
   // handshake is read right after the edge, which still shows the values the
   // parser saw at that edge. Valid is raised or lowered once per step only.
   task automatic send_request(input logic [7:0] data_byte, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{body_byte: data_byte, last_byte: last};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Sends the body in body_q, with the last mark on its final byte.
   task automatic send_body();
      for (int i = 0; i < body_q.size(); i++) begin
         send_request(body_q[i], i == body_q.size() - 1);
      end
   endtask

   // Builds a success body of the given length. The descriptor is legal to
   // begin with; about four bodies in ten then get bits flipped in one
   // descriptor byte, which reaches each of the range and reserved-bit checks.
   // Bytes past the descriptor are random and only add to the length.
   task automatic build_success_body(input int len);
      logic [7:0] d [ndrp_pkg::CAPTURE_DEPTH];

      foreach (d[i]) d[i] = 8'($urandom);
      d[1]      = ndrp_pkg::STATUS_SUCCESS;
      d[4][7:5] = '0;
      d[4][2:0] = 3'($urandom_range(0, ndrp_pkg::LOGICAL_TYPE_MAX));
      d[5][2:0] = '0;
      d[5][4]   = 1'b0;
      d[6][5:4] = '0;
      d[9][7]   = 1'b0;
      d[11][7]  = 1'b0;
      d[12][7]  = 1'b0;
      d[13][0]  = 1'b0;
      d[15][7]  = 1'b0;
      d[16]     = 8'($urandom_range(0, ndrp_pkg::DESC_CAP_MAX));
      if ($urandom_range(99) < 40) begin
         d[$urandom_range(4, ndrp_pkg::CAPTURE_DEPTH - 1)] ^= 8'($urandom_range(1, 255));
      end
      body_q.delete();
      for (int i = 0; i < len; i++) begin
         body_q.push_back(i < ndrp_pkg::CAPTURE_DEPTH ? d[i] : 8'($urandom));
      end
   endtask

   // Builds a short body for one of the statuses that carry no descriptor.
   // Address statuses of two or three bytes come out truncated.
   task automatic build_short_status_body();
      logic [7:0] st;
      int         len;

      case ($urandom_range(3))
         0: st = ndrp_pkg::STATUS_INV_TYPE;
         1: st = ndrp_pkg::STATUS_DEV_NF;
         2: st = ndrp_pkg::STATUS_NOT_FOUND;
         default: st = ndrp_pkg::STATUS_NO_DESC;
      endcase
      len    = $urandom_range(2, 8);
      body_q = '{8'($urandom), st};
      while (body_q.size() < len) body_q.push_back(8'($urandom));
   endtask

   // Builds a body of the given length from random bytes.
   task automatic build_noise_body(input int len);
      body_q.delete();
      repeat (len) body_q.push_back(8'($urandom));
   endtask

   // One random body. Most are well-formed success or short-status bodies
   // with random content; the rest are noise, truncated and oversized bodies.
   task automatic send_random_body();
      int pick;
      int kind;

      pick = $urandom_range(99);
      if (pick < 45) begin
         kind = $urandom_range(9);
         if (kind == 0) begin
            build_success_body($urandom_range(2, ndrp_pkg::CAPTURE_DEPTH - 1));
         end else if (kind == 1) begin
            build_success_body($urandom_range(ndrp_pkg::CAPTURE_DEPTH + 1,
                                              MAX_BODY_BYTES));
         end else begin
            build_success_body(ndrp_pkg::CAPTURE_DEPTH);
         end
      end else if (pick < 80) begin
         build_short_status_body();
      end else if (pick < 93) begin
         build_noise_body($urandom_range(1, 20));
      end else if (pick < 96) begin
         build_success_body($urandom_range(MAX_BODY_BYTES + 1, MAX_BODY_BYTES + 24));
      end else begin
         build_noise_body($urandom_range(MAX_BODY_BYTES + 1, MAX_BODY_BYTES + 24));
      end
      send_body();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed bodies, sent with no idling on either side.
      // A lone byte is too short to hold even a status.
      body_q = '{8'hff};
      send_body();
      // Shortest legal body: the two-byte status without a descriptor.
      body_q = '{8'hff, ndrp_pkg::STATUS_NO_DESC};
      send_body();
      // A status with no known length.
      body_q = '{8'h5a, 8'h01};
      send_body();
      // Address status with the largest address.
      body_q = '{8'h00, ndrp_pkg::STATUS_NOT_FOUND, 8'hff, 8'hff};
      send_body();
      // Success with every descriptor field at its largest legal value.
      body_q = '{8'hff, ndrp_pkg::STATUS_SUCCESS, 8'hff, 8'hff, 8'h1a, 8'he8, 8'hcf,
                 8'hff, 8'hff, 8'h7f, 8'hff, 8'h7f, 8'h7f, 8'hfe, 8'hff, 8'h7f, 8'h03};
      send_body();

      // Slow receiver, sender idles now and then.
      send_idle_pct = 29;
      recv_idle_pct = 85;
      while (items_sent < PHASE_ITEMS) send_random_body();

      // Slow sender, receiver idles now and then.
      send_idle_pct = 85;
      recv_idle_pct = 29;
      while (items_sent < 2 * PHASE_ITEMS) send_random_body();

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // Length edges: exactly at the limit, one past it, and long enough to
      // saturate the byte counter.
      build_success_body(MAX_BODY_BYTES);
      send_body();
      build_success_body(MAX_BODY_BYTES + 1);
      send_body();
      build_noise_body(300);
      send_body();

      // The receiver holds off while short bodies keep coming, so both
      // internal stages fill and the parser has to stall its input.
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (12) begin
         build_short_status_body();
         send_body();
      end

      while (items_sent < 3 * PHASE_ITEMS) send_random_body();
      req_valid <= 1'b0;

      // Let the checker queue the last body's result, then let the results come
      // out and give the parser the DRAIN_CYCLES drain period to show any result
      // that nobody asked for.
      @(posedge clock);
      wait (pending_results == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results == 0) begin
         $display("PASS node_descriptor_response_parser");
      end else begin
         $display("FAIL node_descriptor_response_parser");
      end
      $finish;
   end

endmodule
